// ----- hw/rtl/dtms_pkg.sv -----
package dtms_pkg;

    localparam int NUM_STATES = 64;
    localparam int MAX_LINE   = 4096;

    localparam int STATE_W = 6;
    localparam int SYM_W   = 8;
    localparam int POS_W   = 13;

    // table rows actually addressable by a state field
    localparam int TBL_ROWS  = (NUM_STATES < 2 ** STATE_W) ? NUM_STATES : 2 ** STATE_W;
    localparam int ROW_W     = $clog2(TBL_ROWS);
    localparam int TBL_AW    = ROW_W + SYM_W;
    localparam int TBL_DEPTH = TBL_ROWS * (2 ** SYM_W);
    localparam int ENTRY_W   = STATE_W + 1;

    localparam int FIELD_MAX   = 2 ** POS_W - 1;
    localparam int POS_CAP_INT = (MAX_LINE < FIELD_MAX) ? MAX_LINE : FIELD_MAX;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_INT);

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * POS_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam logic [1:0] ACT_LOAD_ENTRY  = 2'd0;
    localparam logic [1:0] ACT_LOAD_ACCEPT = 2'd1;
    localparam logic [1:0] ACT_SCAN        = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] next;
    } entry_t;

    typedef struct packed {
        logic [POS_W-1:0] match_length;
        logic [POS_W-1:0] end_position;
    } result_t;

    function automatic logic state_in_range(input logic [STATE_W-1:0] s);
        return int'(s) < NUM_STATES;
    endfunction

    function automatic logic [ROW_W-1:0] state_row(input logic [STATE_W-1:0] s);
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v >= POS_CAP) ? POS_CAP : v + POS_W'(1);
    endfunction

endpackage

// ----- hw/rtl/dtms_trans_ram.sv -----
module dtms_trans_ram #(
    parameter int DEPTH = 16384,
    parameter int DW    = 7,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] ra_addr,
    input  logic [AW-1:0] rb_addr,
    output logic [DW-1:0] ra_data,
    output logic [DW-1:0] rb_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

// ----- hw/rtl/dtms_out_fifo.sv -----
module dtms_out_fifo (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  dtms_pkg::result_t              push_data,
    output logic                           pop_valid,
    input  logic                           pop_ready,
    output dtms_pkg::result_t              pop_data,
    output logic [dtms_pkg::FIFO_CW-1:0]   count
);

    dtms_pkg::result_t              mem [dtms_pkg::FIFO_DEPTH];
    logic [dtms_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [dtms_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [dtms_pkg::FIFO_CW-1:0]   count_reg;
    logic [dtms_pkg::FIFO_CW-1:0]   count_next;
    logic                           pop;

    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + dtms_pkg::FIFO_CW'(1);
        end else if (!push && pop) begin
            count_next = count_reg - dtms_pkg::FIFO_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + dtms_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + dtms_pkg::FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/dfa_text_match_scanner_unit.sv -----
// DFA text scanner.
// s_ channel carries load and scan items; tuser selects the action (load transition
// entry, load accepting flag, scan byte), tlast marks the last byte of a text line.
// m_ channel carries one item per match: end position in the line and run length.
// The transition table sits in a one-write, two-read synchronous RAM; port A looks
// up the current state, port B looks up state 0 for the retry after a miss.
// Accepting flags sit in a small synchronous RAM read with the landing state.
// Pipeline: table read, next-state select and flag read, then the match queue.
// Throughput: one item per cycle, loads and scans alike, while s_tready is high.
// The limit is the loop from the RAM read data through the next-state select back
// into the port A address. Reset: table and flags are cleared by a sweep over all
// TBL_DEPTH entries (16384 at 64 states), one entry a cycle, with s_tready low;
// state, position and run clear at once. Stall: matches queue in a 4-entry buffer;
// after the sweep s_tready drops only when that buffer plus the bytes in flight
// could overflow, so a stalled receiver stops the input without losing any match.
module dfa_text_match_scanner_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [5:0] table_state, [13:6] symbol, [19:14] next_state, [20] entry_valid,
    // [21] accepting, [23:22] zero
    input  logic [dtms_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [1:0] action
    input  logic [dtms_pkg::IN_TUSER_W-1:0]     s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [12:0] end_position, [25:13] match_length, [31:26] zero
    output logic [dtms_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    logic [1:0]                       in_action;
    logic [dtms_pkg::STATE_W-1:0]     in_table_state;
    logic [dtms_pkg::SYM_W-1:0]       in_symbol;
    logic [dtms_pkg::STATE_W-1:0]     in_next_state;
    logic                             in_entry_valid;
    logic                             in_accepting;
    logic                             s_accept;

    logic                             clearing_reg;
    logic [dtms_pkg::TBL_AW-1:0]      clr_addr_reg;

    logic [dtms_pkg::STATE_W-1:0]     cur_state_reg;
    logic [dtms_pkg::STATE_W-1:0]     cur_state_next;
    logic [dtms_pkg::POS_W-1:0]       pos_reg;
    logic [dtms_pkg::POS_W-1:0]       pos_next;
    logic [dtms_pkg::POS_W-1:0]       run_reg;
    logic [dtms_pkg::POS_W-1:0]       run_next;

    logic                             acc_mem [dtms_pkg::TBL_ROWS];
    logic                             acc_rd_reg;
    logic                             acc_we;
    logic [dtms_pkg::ROW_W-1:0]       acc_waddr;
    logic                             acc_wdata;

    logic                             s1_valid_reg;
    logic                             s1_last_reg;
    logic                             s2_cand_reg;
    logic [dtms_pkg::POS_W-1:0]       s2_pos_reg;
    logic [dtms_pkg::POS_W-1:0]       s2_run_reg;

    dtms_pkg::entry_t                 qa;
    dtms_pkg::entry_t                 qb;
    dtms_pkg::entry_t                 sel;
    logic                             hit_a;
    logic [dtms_pkg::POS_W-1:0]       run_base;
    logic [dtms_pkg::POS_W-1:0]       pos_inc;
    logic [dtms_pkg::POS_W-1:0]       run_inc;
    logic                             land_cand;
    logic [dtms_pkg::STATE_W-1:0]     eff_state;

    logic                             tbl_we;
    logic [dtms_pkg::TBL_AW-1:0]      tbl_waddr;
    logic [dtms_pkg::ENTRY_W-1:0]     tbl_wdata;
    logic [dtms_pkg::TBL_AW-1:0]      tbl_ra;
    logic [dtms_pkg::TBL_AW-1:0]      tbl_rb;

    logic                             res_push;
    dtms_pkg::result_t                res_data;
    dtms_pkg::result_t                out_data;
    logic [dtms_pkg::FIFO_CW-1:0]     fifo_count;
    logic [dtms_pkg::FIFO_CW-1:0]     occupancy;

    assign in_action      = s_tuser;
    assign in_table_state = s_tdata[5:0];
    assign in_symbol      = s_tdata[13:6];
    assign in_next_state  = s_tdata[19:14];
    assign in_entry_valid = s_tdata[20];
    assign in_accepting   = s_tdata[21];

    // room for the results of the bytes in flight plus one more
    assign occupancy = fifo_count + dtms_pkg::FIFO_CW'(s1_valid_reg) +
                       dtms_pkg::FIFO_CW'(s2_cand_reg);
    assign s_tready  = !clearing_reg &&
                       (occupancy <= dtms_pkg::FIFO_CW'(dtms_pkg::FIFO_DEPTH - 1));
    assign s_accept  = s_tvalid && s_tready;

    // second stage: resolve the lookup of the byte read last cycle
    always_comb begin
        hit_a     = dtms_pkg::state_in_range(cur_state_reg) && qa.valid;
        sel       = hit_a ? qa : qb;
        run_base  = hit_a ? run_reg : '0;
        pos_inc   = dtms_pkg::sat_inc(pos_reg);
        run_inc   = dtms_pkg::sat_inc(run_base);
        land_cand = sel.valid && dtms_pkg::state_in_range(sel.next);

        cur_state_next = sel.valid ? sel.next : '0;
        run_next       = sel.valid ? run_inc : '0;
        pos_next       = pos_inc;
        if (s1_last_reg) begin
            cur_state_next = '0;
            run_next       = '0;
            pos_next       = '0;
        end

        // state seen by a byte entering this cycle
        eff_state = s1_valid_reg ? cur_state_next : cur_state_reg;
    end

    // third stage: flag of the landing state decides the match
    assign res_push = s2_cand_reg && acc_rd_reg;
    assign res_data = '{match_length: s2_run_reg, end_position: s2_pos_reg};

    assign tbl_we    = clearing_reg ||
                       (s_accept && in_action == dtms_pkg::ACT_LOAD_ENTRY &&
                        dtms_pkg::state_in_range(in_table_state));
    assign tbl_waddr = clearing_reg ? clr_addr_reg
                                    : {dtms_pkg::state_row(in_table_state), in_symbol};
    assign tbl_wdata = clearing_reg ? '0 : {in_entry_valid, in_next_state};
    assign tbl_ra    = {dtms_pkg::state_row(eff_state), in_symbol};
    assign tbl_rb    = {dtms_pkg::ROW_W'(0), in_symbol};

    assign acc_we    = clearing_reg ||
                       (s_accept && in_action == dtms_pkg::ACT_LOAD_ACCEPT &&
                        dtms_pkg::state_in_range(in_table_state));
    assign acc_waddr = clearing_reg ? clr_addr_reg[dtms_pkg::ROW_W-1:0]
                                    : dtms_pkg::state_row(in_table_state);
    assign acc_wdata = !clearing_reg && in_accepting;

    dtms_trans_ram #(
        .DEPTH (dtms_pkg::TBL_DEPTH),
        .DW    (dtms_pkg::ENTRY_W)
    ) u_trans_ram (
        .aclk    (aclk),
        .we      (tbl_we),
        .waddr   (tbl_waddr),
        .wdata   (tbl_wdata),
        .ra_addr (tbl_ra),
        .rb_addr (tbl_rb),
        .ra_data (qa),
        .rb_data (qb)
    );

    dtms_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .pop_valid (m_tvalid),
        .pop_ready (m_tready),
        .pop_data  (out_data),
        .count     (fifo_count)
    );

    assign m_tdata = {dtms_pkg::OUT_PAD_W'(0), out_data};

    // a flag write and a read of the same entry at one edge return the old flag,
    // which belongs to the earlier scan byte
    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_rd_reg <= acc_mem[dtms_pkg::state_row(sel.next)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + dtms_pkg::TBL_AW'(1);
            if (clr_addr_reg == dtms_pkg::TBL_AW'(dtms_pkg::TBL_DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_state_reg <= '0;
            pos_reg       <= '0;
            run_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_cand_reg   <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept && in_action == dtms_pkg::ACT_SCAN;
            s2_cand_reg  <= s1_valid_reg && land_cand;
            if (s1_valid_reg) begin
                cur_state_reg <= cur_state_next;
                pos_reg       <= pos_next;
                run_reg       <= run_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_last_reg <= s_tlast;
        end
        if (s1_valid_reg) begin
            s2_pos_reg <= pos_inc;
            s2_run_reg <= run_inc;
        end
    end

`ifndef SYNTH
    a_fifo_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_push && !(m_tvalid && m_tready)) |->
            fifo_count < dtms_pkg::FIFO_CW'(dtms_pkg::FIFO_DEPTH))
        else $error("match queue overflow");

    a_line_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_last_reg) |=>
            (cur_state_reg == '0 && pos_reg == '0 && run_reg == '0))
        else $error("line end did not return scanner to start");

    a_run_within_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg <= pos_reg)
        else $error("run length exceeds line position");

    a_no_scan_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s1_valid_reg && !res_push)
        else $error("scan in flight during table clear");
`endif

endmodule
